FILE: rtl/line_crossing_counter_core_macros.svh
// ----------------------------------------------------------------------------
// line crossing counter assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef LINE_CROSSING_COUNTER_CORE_MACROS_SVH
`define LINE_CROSSING_COUNTER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define LCC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lcc assertion failed");
`define LCC_ASSERT_NEVER(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) !(prop)) \
      else $error("lcc forbidden condition seen");
`else
`define LCC_ASSERT(label, clk, rst, prop)
`define LCC_ASSERT_NEVER(label, clk, rst, prop)
`endif
`endif

FILE: rtl/lcc_pkg.sv
// ----------------------------------------------------------------------------
// lcc_pkg
// shared widths, codes and controller-datapath command types
// ----------------------------------------------------------------------------
package lcc_pkg;

   localparam int OBJECT_ID_W = 6;
   localparam int POS_W       = 16;
   localparam int MODE_W      = 2;
   localparam int DIR_W       = 2;
   localparam int COUNT_W     = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // signed multiplier operands, product and accumulator
   localparam int OPERAND_W = POS_W + 1;
   localparam int PROD_W    = 2 * OPERAND_W;
   localparam int ACC_W     = PROD_W + 2;

   localparam logic [CSR_INDEX_W-1:0] REG_LINE_START_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LINE_START_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LINE_END_X   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LINE_END_Y   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_COUNT_MODE   = 3'd4;

   localparam logic [POS_W-1:0]  RST_LINE_START_X = 16'd320;
   localparam logic [POS_W-1:0]  RST_LINE_START_Y = 16'd480;
   localparam logic [POS_W-1:0]  RST_LINE_END_X   = 16'd3840;
   localparam logic [POS_W-1:0]  RST_LINE_END_Y   = 16'd4320;
   localparam logic [MODE_W-1:0] RST_COUNT_MODE   = 2'd2;

   localparam logic [MODE_W-1:0] MODE_NEG_TO_POS = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POS_TO_NEG = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BOTH       = 2'd2;

   localparam logic [DIR_W-1:0] DIR_NONE       = 2'd0;
   localparam logic [DIR_W-1:0] DIR_NEG_TO_POS = 2'd1;
   localparam logic [DIR_W-1:0] DIR_POS_TO_NEG = 2'd2;

   typedef enum logic [1:0] {
      MUL_A_PX,
      MUL_B_PY,
      MUL_Y1_X2,
      MUL_X1_Y2
   } mul_sel_type;

   typedef struct packed {
      logic        accept;
      logic        clear_we;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        acc_clear;
      logic        acc_en;
      logic        update;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } status_type;

endpackage

FILE: rtl/lcc_ram.sv
// ----------------------------------------------------------------------------
// lcc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lcc_ctrl.sv
// ----------------------------------------------------------------------------
// lcc_ctrl
// sequencer: reset clear pass, four multiply steps, accumulate, update, strobe
// ----------------------------------------------------------------------------
module lcc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_strobe,
   output lcc_pkg::cmd_type    cmd,
   input  lcc_pkg::status_type status
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_ACC,
      ST_UPDATE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;
   logic      strobe_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_MUL0;
            end
         end
         ST_MUL0:   state_in = ST_MUL1;
         ST_MUL1:   state_in = ST_MUL2;
         ST_MUL2:   state_in = ST_MUL3;
         ST_MUL3:   state_in = ST_ACC;
         ST_ACC:    state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         busy_ff   <= 1'b1;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= (state_in != ST_IDLE);
         strobe_ff <= (state_ff == ST_UPDATE);
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.mul_sel   = lcc_pkg::MUL_A_PX;
      cmd.accept    = start && !busy_ff;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_we = 1'b1;
         ST_MUL0: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = lcc_pkg::MUL_A_PX;
            cmd.acc_clear = 1'b1;
         end
         ST_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = lcc_pkg::MUL_B_PY;
            cmd.acc_en  = 1'b1;
         end
         ST_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = lcc_pkg::MUL_Y1_X2;
            cmd.acc_en  = 1'b1;
         end
         ST_MUL3: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = lcc_pkg::MUL_X1_Y2;
            cmd.acc_en  = 1'b1;
         end
         ST_ACC:    cmd.acc_en = 1'b1;
         ST_UPDATE: cmd.update = 1'b1;
         default:   cmd.update = 1'b0;
      endcase
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

FILE: rtl/lcc_datapath.sv
// ----------------------------------------------------------------------------
// lcc_datapath
// line registers, shared side-of-line multiplier, per-id history and counters
// ----------------------------------------------------------------------------
module lcc_datapath #(
   parameter int MAX_OBJECTS   = 64,
   parameter int HISTORY_DEPTH = 6
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lcc_pkg::cmd_type                     cmd,
   output lcc_pkg::status_type                  status,
   input  logic                                 csr_write_enable,
   input  logic [lcc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lcc_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  logic [lcc_pkg::OBJECT_ID_W-1:0]      req_object_id,
   input  logic [lcc_pkg::POS_W-1:0]            req_pos_x,
   input  logic [lcc_pkg::POS_W-1:0]            req_pos_y,
   output logic [lcc_pkg::DIR_W-1:0]            rsp_direction,
   output logic                                 rsp_counted,
   output logic                                 rsp_was_ignored,
   output logic [lcc_pkg::COUNT_W-1:0]          rsp_total_neg_to_pos,
   output logic [lcc_pkg::COUNT_W-1:0]          rsp_total_pos_to_neg
);

   localparam int IDX_W      = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
   localparam int ID_COUNT   = 2 ** lcc_pkg::OBJECT_ID_W;
   localparam int LEN_W      = $clog2(HISTORY_DEPTH + 1);
   localparam int HIST_IDX_W = $clog2(HISTORY_DEPTH);
   localparam int STATE_W    = LEN_W + 1;
   localparam int OP_W       = lcc_pkg::OPERAND_W;
   localparam int PROD_W     = lcc_pkg::PROD_W;
   localparam int ACC_W      = lcc_pkg::ACC_W;

   // id to entry map, wrapping at MAX_OBJECTS
   function automatic logic [ID_COUNT*IDX_W-1:0] build_id_map();
      logic [ID_COUNT*IDX_W-1:0] map;
      int unsigned               r;
      map = '0;
      r   = 0;
      for (int i = 0; i < ID_COUNT; i++) begin
         map[i*IDX_W +: IDX_W] = IDX_W'(r);
         if (r + 1 >= MAX_OBJECTS) begin
            r = 0;
         end else begin
            r = r + 1;
         end
      end
      return map;
   endfunction

   localparam logic [ID_COUNT*IDX_W-1:0] ID_MAP = build_id_map();

   logic [lcc_pkg::POS_W-1:0]   line_start_x_ff;
   logic [lcc_pkg::POS_W-1:0]   line_start_y_ff;
   logic [lcc_pkg::POS_W-1:0]   line_end_x_ff;
   logic [lcc_pkg::POS_W-1:0]   line_end_y_ff;
   logic [lcc_pkg::MODE_W-1:0]  count_mode_ff;

   logic [lcc_pkg::POS_W-1:0]   pos_x_ff;
   logic [lcc_pkg::POS_W-1:0]   pos_y_ff;
   logic [IDX_W-1:0]            id_ff;
   logic [IDX_W-1:0]            rd_id;

   logic signed [OP_W-1:0]      coef_a;
   logic signed [OP_W-1:0]      coef_b;
   logic signed [OP_W-1:0]      op_a;
   logic signed [OP_W-1:0]      op_b;
   logic signed [PROD_W-1:0]    prod_in;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [ACC_W-1:0]     acc_ff;
   logic                        side_pos;

   logic [IDX_W-1:0]            clear_cnt_ff;

   logic [HISTORY_DEPTH-1:0]    hist_rd;
   logic [STATE_W-1:0]          state_rd;
   logic                        ign_rd;
   logic [LEN_W-1:0]            len_rd;
   logic [HISTORY_DEPTH-1:0]    hist_new;
   logic [LEN_W-1:0]            len_new;
   logic [LEN_W-1:0]            len_m1;
   logic                        oldest;
   logic                        found;
   logic                        count_n2p;
   logic                        count_p2n;
   logic                        counted;
   logic [LEN_W-1:0]            len_wr;

   logic                        hist_we;
   logic [HISTORY_DEPTH-1:0]    hist_wr_data;
   logic                        state_we;
   logic [IDX_W-1:0]            state_wr_addr;
   logic [STATE_W-1:0]          state_wr_data;

   logic [lcc_pkg::COUNT_W-1:0] n2p_ff;
   logic [lcc_pkg::COUNT_W-1:0] p2n_ff;
   logic [lcc_pkg::DIR_W-1:0]   dir_in;
   logic [lcc_pkg::DIR_W-1:0]   rsp_direction_ff;
   logic                        rsp_counted_ff;
   logic                        rsp_was_ignored_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         line_start_x_ff <= lcc_pkg::RST_LINE_START_X;
         line_start_y_ff <= lcc_pkg::RST_LINE_START_Y;
         line_end_x_ff   <= lcc_pkg::RST_LINE_END_X;
         line_end_y_ff   <= lcc_pkg::RST_LINE_END_Y;
         count_mode_ff   <= lcc_pkg::RST_COUNT_MODE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lcc_pkg::REG_LINE_START_X: line_start_x_ff <= csr_write_data;
            lcc_pkg::REG_LINE_START_Y: line_start_y_ff <= csr_write_data;
            lcc_pkg::REG_LINE_END_X:   line_end_x_ff   <= csr_write_data;
            lcc_pkg::REG_LINE_END_Y:   line_end_y_ff   <= csr_write_data;
            lcc_pkg::REG_COUNT_MODE:
               count_mode_ff <= csr_write_data[lcc_pkg::MODE_W-1:0];
            default: count_mode_ff <= count_mode_ff;
         endcase
      end
   end

   // request capture
   assign rd_id = ID_MAP[int'(req_object_id)*IDX_W +: IDX_W];

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pos_x_ff <= req_pos_x;
         pos_y_ff <= req_pos_y;
         id_ff    <= rd_id;
      end
   end

   // side of line: a*x + b*y + (y1*x2 - x1*y2)
   assign coef_a = $signed({1'b0, line_end_y_ff}) - $signed({1'b0, line_start_y_ff});
   assign coef_b = $signed({1'b0, line_start_x_ff}) - $signed({1'b0, line_end_x_ff});

   always_comb begin
      unique case (cmd.mul_sel)
         lcc_pkg::MUL_A_PX: begin
            op_a = coef_a;
            op_b = $signed({1'b0, pos_x_ff});
         end
         lcc_pkg::MUL_B_PY: begin
            op_a = coef_b;
            op_b = $signed({1'b0, pos_y_ff});
         end
         lcc_pkg::MUL_Y1_X2: begin
            op_a = $signed({1'b0, line_start_y_ff});
            op_b = $signed({1'b0, line_end_x_ff});
         end
         lcc_pkg::MUL_X1_Y2: begin
            op_a = -$signed({1'b0, line_start_x_ff});
            op_b = $signed({1'b0, line_end_y_ff});
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   // zero counts as negative
   assign side_pos = !acc_ff[ACC_W-1] && (acc_ff != '0);

   // clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else if (cmd.clear_we) begin
         clear_cnt_ff <= clear_cnt_ff + IDX_W'(1);
      end
   end

   assign status.clear_last = (clear_cnt_ff == IDX_W'(MAX_OBJECTS - 1));

   // per-id stores
   lcc_ram #(
      .WIDTH (HISTORY_DEPTH),
      .DEPTH (MAX_OBJECTS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (id_ff),
      .wr_data (hist_wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (rd_id),
      .rd_data (hist_rd)
   );

   lcc_ram #(
      .WIDTH (STATE_W),
      .DEPTH (MAX_OBJECTS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (state_we),
      .wr_addr (state_wr_addr),
      .wr_data (state_wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (rd_id),
      .rd_data (state_rd)
   );

   // history update and crossing decision
   assign {ign_rd, len_rd} = state_rd;
   assign hist_new = {hist_rd[HISTORY_DEPTH-2:0], side_pos};
   assign len_new  = (len_rd < LEN_W'(HISTORY_DEPTH)) ? len_rd + LEN_W'(1) : len_rd;
   assign len_m1   = len_new - LEN_W'(1);
   assign oldest   = hist_new[len_m1[HIST_IDX_W-1:0]];
   assign found    = (len_new >= LEN_W'(2)) && (oldest != side_pos);

   assign count_n2p = !ign_rd && found && !oldest &&
                      ((count_mode_ff == lcc_pkg::MODE_NEG_TO_POS) ||
                       (count_mode_ff == lcc_pkg::MODE_BOTH));
   assign count_p2n = !ign_rd && found && oldest &&
                      ((count_mode_ff == lcc_pkg::MODE_POS_TO_NEG) ||
                       (count_mode_ff == lcc_pkg::MODE_BOTH));
   assign counted   = count_n2p || count_p2n;
   assign len_wr    = counted ? '0 : len_new;

   always_comb begin
      priority if (ign_rd || !found) begin
         dir_in = lcc_pkg::DIR_NONE;
      end else if (!oldest) begin
         dir_in = lcc_pkg::DIR_NEG_TO_POS;
      end else begin
         dir_in = lcc_pkg::DIR_POS_TO_NEG;
      end
   end

   assign hist_we       = cmd.update && !ign_rd;
   assign hist_wr_data  = counted ? '0 : hist_new;
   assign state_we      = cmd.clear_we || (cmd.update && !ign_rd);
   assign state_wr_addr = cmd.clear_we ? clear_cnt_ff : id_ff;
   assign state_wr_data = cmd.clear_we ? '0 : {counted, len_wr};

   // totals
   always_ff @(posedge clock) begin
      if (reset) begin
         n2p_ff <= '0;
         p2n_ff <= '0;
      end else if (cmd.update) begin
         if (count_n2p) begin
            n2p_ff <= n2p_ff + lcc_pkg::COUNT_W'(1);
         end
         if (count_p2n) begin
            p2n_ff <= p2n_ff + lcc_pkg::COUNT_W'(1);
         end
      end
   end

   // response
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_direction_ff   <= dir_in;
         rsp_counted_ff     <= counted;
         rsp_was_ignored_ff <= ign_rd;
      end
   end

   assign rsp_direction        = rsp_direction_ff;
   assign rsp_counted          = rsp_counted_ff;
   assign rsp_was_ignored      = rsp_was_ignored_ff;
   assign rsp_total_neg_to_pos = n2p_ff;
   assign rsp_total_pos_to_neg = p2n_ff;

endmodule

FILE: rtl/line_crossing_counter_core.sv
// ----------------------------------------------------------------------------
// line_crossing_counter_core
// a request steps through four multiply states, then accumulate and update
// no new request is taken while busy, as the single shared multiplier
//    steps through four products and the per-id read-modify-write
// reset: busy stays high for a clearing pass over every per-id state entry
// rsp_strobe is high for one cycle per request; the receiver cannot stall
// ----------------------------------------------------------------------------
`include "line_crossing_counter_core_macros.svh"

module line_crossing_counter_core #(
   parameter int MAX_OBJECTS   = 64,
   parameter int HISTORY_DEPTH = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [lcc_pkg::OBJECT_ID_W-1:0] req_object_id,
   input  logic [lcc_pkg::POS_W-1:0]       req_pos_x,
   input  logic [lcc_pkg::POS_W-1:0]       req_pos_y,
   output logic                            rsp_strobe,
   output logic [lcc_pkg::DIR_W-1:0]       rsp_direction,
   output logic                            rsp_counted,
   output logic                            rsp_was_ignored,
   output logic [lcc_pkg::COUNT_W-1:0]     rsp_total_neg_to_pos,
   output logic [lcc_pkg::COUNT_W-1:0]     rsp_total_pos_to_neg,
   input  logic                            csr_write_enable,
   input  logic [lcc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lcc_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   lcc_pkg::cmd_type    cmd;
   lcc_pkg::status_type status;

   lcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   lcc_datapath #(
      .MAX_OBJECTS   (MAX_OBJECTS),
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_object_id        (req_object_id),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .rsp_direction        (rsp_direction),
      .rsp_counted          (rsp_counted),
      .rsp_was_ignored      (rsp_was_ignored),
      .rsp_total_neg_to_pos (rsp_total_neg_to_pos),
      .rsp_total_pos_to_neg (rsp_total_pos_to_neg)
   );

   `LCC_ASSERT(a_accept_then_busy, clock, reset, start && !busy |=> busy)
   `LCC_ASSERT(a_accept_to_strobe, clock, reset, start && !busy |-> ##7 rsp_strobe)
   `LCC_ASSERT(a_strobe_single, clock, reset, rsp_strobe |=> !rsp_strobe)
   `LCC_ASSERT(a_strobe_idle, clock, reset, rsp_strobe |-> !busy)
   `LCC_ASSERT_NEVER(a_counted_no_dir, clock, reset,
      rsp_strobe && rsp_counted && (rsp_direction == lcc_pkg::DIR_NONE))
   `LCC_ASSERT_NEVER(a_ignored_counted, clock, reset,
      rsp_strobe && rsp_was_ignored && rsp_counted)

endmodule
